// ----- design/eul_pkg.sv -----
`default_nettype none

package eul_pkg;

	localparam int ANGLE_BITS_DEF = 16;
	localparam int ENTRY_FRAC_BITS_DEF = 14;

	localparam int FIELD_BITS = 16;
	localparam int PHASE_BITS = 32;
	localparam int LANE_COUNT = 6;
	localparam int ENTRY_COUNT = 9;

	localparam logic [31:0] QONE = 32'h4000_0000;
	localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

	localparam int DIV_COUNT = 5;
	localparam int unsigned DIV_K [DIV_COUNT] = '{110, 72, 42, 20, 6};
	localparam int unsigned DIV_L [DIV_COUNT] = '{7, 7, 6, 5, 3};

	localparam int SIN_STAGES = 2 * DIV_COUNT + 4;
	localparam int MERGE_STAGES = 4;
	localparam int PIPE_STAGES = SIN_STAGES + MERGE_STAGES;

	typedef logic signed [31:0] sine_t;
	typedef logic signed [33:0] sum_t;
	typedef logic signed [FIELD_BITS-1:0] entry_t;

endpackage

`default_nettype wire

// ----- design/euler_angles_to_rotation_matrix_unit.sv -----
// Throughput: one angle triple per cycle unless rot_stall holds back a full pipeline, set by
// the six sine/cosine lanes (14-stage series pipeline each) followed by the 4-stage product
// and rounding merge, which carry each angle transfer to its matching matrix on rot_valid.
// A stalled result holds in the last stage while earlier stages keep filling bubbles.
// Reset clears the stage valid flags only; the data registers are not reset.
`default_nettype none

module euler_angles_to_rotation_matrix_unit import eul_pkg::*; #(
	parameter int ANGLE_BITS = ANGLE_BITS_DEF,
	parameter int ENTRY_FRAC_BITS = ENTRY_FRAC_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         angle_valid,
	output logic                              angle_stall,
	input  wire logic signed [FIELD_BITS-1:0] angle_alpha,
	input  wire logic signed [FIELD_BITS-1:0] angle_beta,
	input  wire logic signed [FIELD_BITS-1:0] angle_gamma,
	output logic                              rot_valid,
	input  wire logic                         rot_stall,
	output logic signed [FIELD_BITS-1:0]      rot_r0_c0,
	output logic signed [FIELD_BITS-1:0]      rot_r1_c0,
	output logic signed [FIELD_BITS-1:0]      rot_r2_c0,
	output logic signed [FIELD_BITS-1:0]      rot_r0_c1,
	output logic signed [FIELD_BITS-1:0]      rot_r1_c1,
	output logic signed [FIELD_BITS-1:0]      rot_r2_c1,
	output logic signed [FIELD_BITS-1:0]      rot_r0_c2,
	output logic signed [FIELD_BITS-1:0]      rot_r1_c2,
	output logic signed [FIELD_BITS-1:0]      rot_r2_c2
);

	localparam int PHASE_SHIFT = PHASE_BITS - ANGLE_BITS;

	logic [PIPE_STAGES-1:0] valid_q;
	logic [PIPE_STAGES-1:0] ready;

	logic [PHASE_BITS-1:0] phase_a, phase_b, phase_g;
	logic [PHASE_BITS-1:0] lane_phase [LANE_COUNT];
	sine_t                 lane_sine  [LANE_COUNT];
	entry_t                entry      [ENTRY_COUNT];

	for (genvar i = 0; i < PIPE_STAGES; i++) begin : g_ready
		localparam logic [PIPE_STAGES-1:0] LOW_MASK = PIPE_STAGES'((64'd1 << i) - 64'd1);
		assign ready[i] = ~rot_stall | ~&(valid_q | LOW_MASK);
	end

	assign angle_stall = ~ready[0];
	assign rot_valid = valid_q[PIPE_STAGES-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			for (int i = 0; i < PIPE_STAGES; i++) begin
				if (ready[i]) begin
					valid_q[i] <= (i == 0) ? angle_valid : valid_q[(i == 0) ? 0 : i-1];
				end
			end
		end
	end

	assign phase_a = PHASE_BITS'(PHASE_BITS'(angle_alpha) << PHASE_SHIFT);
	assign phase_b = PHASE_BITS'(PHASE_BITS'(angle_beta) << PHASE_SHIFT);
	assign phase_g = PHASE_BITS'(PHASE_BITS'(angle_gamma) << PHASE_SHIFT);

	assign lane_phase[0] = phase_a;
	assign lane_phase[1] = phase_a + QONE;
	assign lane_phase[2] = phase_b;
	assign lane_phase[3] = phase_b + QONE;
	assign lane_phase[4] = phase_g;
	assign lane_phase[5] = phase_g + QONE;

	for (genvar l = 0; l < LANE_COUNT; l++) begin : g_lane
		eul_sin_lane u_lane (
			.clk   (clk),
			.en    (ready[SIN_STAGES-1:0]),
			.phase (lane_phase[l]),
			.sine  (lane_sine[l])
		);
	end

	eul_merge #(
		.ENTRY_FRAC_BITS (ENTRY_FRAC_BITS)
	) u_merge (
		.clk   (clk),
		.en    (ready[PIPE_STAGES-1:SIN_STAGES]),
		.sa    (lane_sine[0]),
		.ca    (lane_sine[1]),
		.sb    (lane_sine[2]),
		.cb    (lane_sine[3]),
		.sg    (lane_sine[4]),
		.cg    (lane_sine[5]),
		.entry (entry)
	);

	assign rot_r0_c0 = entry[0];
	assign rot_r1_c0 = entry[1];
	assign rot_r2_c0 = entry[2];
	assign rot_r0_c1 = entry[3];
	assign rot_r1_c1 = entry[4];
	assign rot_r2_c1 = entry[5];
	assign rot_r0_c2 = entry[6];
	assign rot_r1_c2 = entry[7];
	assign rot_r2_c2 = entry[8];

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		angle_stall |-> (rot_valid && rot_stall && (&valid_q)))
		else $error("input stalled while the pipeline has room");

	a_free_output_free_input: assert property (@(posedge clk) disable iff (!arst_n)
		!rot_stall |-> !angle_stall)
		else $error("input stalled while the output drains");

	a_transfer_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(angle_valid && !angle_stall) |=> valid_q[0])
		else $error("accepted transfer lost at the first stage");

endmodule

`default_nettype wire

// ----- design/eul_sin_lane.sv -----
`default_nettype none

module eul_sin_lane import eul_pkg::*; (
	input  wire logic                  clk,
	input  wire logic [SIN_STAGES-1:0] en,
	input  wire logic [PHASE_BITS-1:0] phase,
	output sine_t                      sine
);

	localparam int ITER_STAGES = 2 * DIV_COUNT;

	logic [1:0]  quad_s1;
	logic [30:0] rm_s1;
	logic [1:0]  quad_s2;
	logic [30:0] x_s2;
	logic [1:0]  quad_s3;
	logic [30:0] x_s3;
	logic [31:0] x2_s3;

	logic [1:0]  quad_c [ITER_STAGES];
	logic [30:0] x_c    [ITER_STAGES];
	logic [31:0] x2_c   [ITER_STAGES-2];
	logic [31:0] work_s [ITER_STAGES];

	logic [61:0] half_pi_prod;
	logic [63:0] x_sq_prod;
	logic [63:0] fin_prod;
	logic [31:0] fin_mag;

	assign half_pi_prod = 62'(rm_s1) * 62'(HALF_PI_Q30);
	assign x_sq_prod = 64'(x_s2) * 64'(x_s2);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			quad_s1 <= phase[31:30];
			rm_s1 <= phase[30] ? (31'(QONE) - {1'b0, phase[29:0]}) : {1'b0, phase[29:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			quad_s2 <= quad_s1;
			x_s2 <= half_pi_prod[60:30];
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			quad_s3 <= quad_s2;
			x_s3 <= x_s2;
			x2_s3 <= x_sq_prod[61:30];
		end
	end

	for (genvar j = 0; j < ITER_STAGES; j++) begin : g_iter
		always_ff @(posedge clk) begin
			if (en[3+j]) begin
				quad_c[j] <= (j == 0) ? quad_s3 : quad_c[(j == 0) ? 0 : j-1];
				x_c[j] <= (j == 0) ? x_s3 : x_c[(j == 0) ? 0 : j-1];
			end
		end

		if (j < ITER_STAGES - 2) begin : g_x2
			always_ff @(posedge clk) begin
				if (en[3+j]) begin
					x2_c[j] <= (j == 0) ? x2_s3 : x2_c[(j == 0) ? 0 : j-1];
				end
			end
		end

		if (j == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (en[3]) begin
					work_s[0] <= x2_s3;
				end
			end
		end else if ((j % 2) == 0) begin : g_mul
			logic [63:0] prod;
			assign prod = 64'(x2_c[j-1]) * 64'(work_s[j-1]);
			always_ff @(posedge clk) begin
				if (en[3+j]) begin
					work_s[j] <= prod[61:30];
				end
			end
		end else begin : g_div
			localparam int SHIFT = PHASE_BITS + int'(DIV_L[j/2]);
			localparam logic [32:0] RECIP = 33'(((65'd1 << SHIFT) + 65'(DIV_K[j/2] - 1))
				/ 65'(DIV_K[j/2]));
			logic [64:0] prod;
			logic [64:0] quot;
			assign prod = 65'(work_s[j-1]) * 65'(RECIP);
			assign quot = prod >> SHIFT;
			always_ff @(posedge clk) begin
				if (en[3+j]) begin
					work_s[j] <= QONE - quot[31:0];
				end
			end
		end
	end

	assign fin_prod = 64'(x_c[ITER_STAGES-1]) * 64'(work_s[ITER_STAGES-1]);
	assign fin_mag = fin_prod[61:30];

	always_ff @(posedge clk) begin
		if (en[SIN_STAGES-1]) begin
			sine <= quad_c[ITER_STAGES-1][1] ? sine_t'(32'd0 - fin_mag) : sine_t'(fin_mag);
		end
	end

endmodule

`default_nettype wire

// ----- design/eul_merge.sv -----
`default_nettype none

module eul_merge import eul_pkg::*; #(
	parameter int ENTRY_FRAC_BITS = ENTRY_FRAC_BITS_DEF
) (
	input  wire logic                    clk,
	input  wire logic [MERGE_STAGES-1:0] en,
	input  wire sine_t                   sa,
	input  wire sine_t                   ca,
	input  wire sine_t                   sb,
	input  wire sine_t                   cb,
	input  wire sine_t                   sg,
	input  wire sine_t                   cg,
	output entry_t                       entry [ENTRY_COUNT]
);

	localparam int RND_SHIFT = 30 - ENTRY_FRAC_BITS;
	localparam logic [34:0] RND_HALF = (RND_SHIFT > 0) ? (35'd1 << (RND_SHIFT - 1)) : 35'd0;

	function automatic sine_t mulq(input sine_t a, input sine_t b);
		logic [31:0] ma;
		logic [31:0] mb;
		logic [63:0] p;
		logic [31:0] m;
		ma = a[31] ? 32'(-a) : 32'(a);
		mb = b[31] ? 32'(-b) : 32'(b);
		p = 64'(ma) * 64'(mb);
		m = p[61:30];
		return (a[31] ^ b[31]) ? sine_t'(32'd0 - m) : sine_t'(m);
	endfunction

	function automatic entry_t to_entry(input sum_t v);
		logic        neg;
		logic [33:0] mag;
		logic [34:0] rnd;
		neg = v[33];
		mag = neg ? 34'(-v) : 34'(v);
		rnd = (35'(mag) + RND_HALF) >> RND_SHIFT;
		if (neg) begin
			return (rnd > 35'd32768) ? entry_t'(-32768) : entry_t'(16'd0 - rnd[15:0]);
		end
		return (rnd > 35'd32767) ? entry_t'(32767) : entry_t'(rnd[15:0]);
	endfunction

	sine_t sb_s1, sg_s1;
	sine_t p_cb_sg_s1, p_cb_cg_s1, p_ca_cb_s1, p_cg_sa_s1, p_ca_sb_s1;
	sine_t p_ca_cg_s1, p_cb_sa_s1, p_sa_sb_s1, p_sa_sg_s1, p_ca_sg_s1;

	sine_t sb_s2;
	sine_t p_cb_sg_s2, p_cb_cg_s2, p_ca_cb_s2, p_cg_sa_s2;
	sine_t p_ca_cg_s2, p_cb_sa_s2, p_sa_sb_s2, p_sa_sg_s2, p_ca_sg_s2;
	sine_t p_ca_sb_sg_s2, p_ca_cg_sb_s2, p_sa_sb_sg_s2;

	sum_t sum_s3 [ENTRY_COUNT];

	always_ff @(posedge clk) begin
		if (en[0]) begin
			sb_s1 <= sb;
			sg_s1 <= sg;
			p_cb_sg_s1 <= mulq(cb, sg);
			p_cb_cg_s1 <= mulq(cb, cg);
			p_ca_cb_s1 <= mulq(ca, cb);
			p_cg_sa_s1 <= mulq(cg, sa);
			p_ca_sb_s1 <= mulq(ca, sb);
			p_ca_cg_s1 <= mulq(ca, cg);
			p_cb_sa_s1 <= mulq(cb, sa);
			p_sa_sb_s1 <= mulq(sa, sb);
			p_sa_sg_s1 <= mulq(sa, sg);
			p_ca_sg_s1 <= mulq(ca, sg);
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			sb_s2 <= sb_s1;
			p_cb_sg_s2 <= p_cb_sg_s1;
			p_cb_cg_s2 <= p_cb_cg_s1;
			p_ca_cb_s2 <= p_ca_cb_s1;
			p_cg_sa_s2 <= p_cg_sa_s1;
			p_ca_cg_s2 <= p_ca_cg_s1;
			p_cb_sa_s2 <= p_cb_sa_s1;
			p_sa_sb_s2 <= p_sa_sb_s1;
			p_sa_sg_s2 <= p_sa_sg_s1;
			p_ca_sg_s2 <= p_ca_sg_s1;
			p_ca_sb_sg_s2 <= mulq(p_ca_sb_s1, sg_s1);
			p_ca_cg_sb_s2 <= mulq(p_ca_cg_s1, sb_s1);
			p_sa_sb_sg_s2 <= mulq(p_sa_sb_s1, sg_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			sum_s3[0] <= 34'(sb_s2);
			sum_s3[1] <= -34'(p_cb_sg_s2);
			sum_s3[2] <= 34'(p_cb_cg_s2);
			sum_s3[3] <= 34'(p_ca_cb_s2);
			sum_s3[4] <= 34'(p_cg_sa_s2) + 34'(p_ca_sb_sg_s2);
			sum_s3[5] <= 34'(p_sa_sg_s2) - 34'(p_ca_cg_sb_s2);
			sum_s3[6] <= -34'(p_cb_sa_s2);
			sum_s3[7] <= 34'(p_ca_cg_s2) - 34'(p_sa_sb_sg_s2);
			sum_s3[8] <= 34'(p_sa_sb_s2) + 34'(p_ca_sg_s2);
		end
	end

	for (genvar e = 0; e < ENTRY_COUNT; e++) begin : g_entry
		always_ff @(posedge clk) begin
			if (en[3]) begin
				entry[e] <= to_entry(sum_s3[e]);
			end
		end
	end

endmodule

`default_nettype wire
